// ===== design/radius_pap_password_hiding_macros.svh =====
// Assertion macros for the RADIUS password hiding block.
// Used by the port checker; depends on nothing else.
`ifndef RADIUS_PAP_PASSWORD_HIDING_MACROS_SVH
`define RADIUS_PAP_PASSWORD_HIDING_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define RPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define RPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== design/rph_pkg.sv =====
// Shared types and constants for the RADIUS password hiding block.
// No dependencies.
package rph_pkg;
	localparam int BLOCK_BYTES  = 16;
	localparam int SECRET_WORDS = 6;
	localparam int CFG_IDX_W    = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SECRET_LENGTH = 3'd0;
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_ENCODE = 1'b1;

	typedef logic [31:0] word_t;

	// control from the sequencer to the round core
	typedef struct packed {
		logic init;
		logic round;
		logic fold;
		logic [5:0] idx;
	} core_ctl_t;

	function automatic word_t md5_k(input logic [5:0] i);
		word_t k;
		unique case (i)
			6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_rot(input logic [5:0] i);
		logic [4:0] s;
		unique case ({i[5:4], i[1:0]})
			4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
			4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
			4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] g;
		unique case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
			2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
			default: g = 4'(i[3:0] * 4'd7);
		endcase
		return g;
	endfunction
endpackage

// ===== design/rph_md5_core.sv =====
// One shared MD5 round unit, one round per cycle, with chaining fold.
// Depends on rph_pkg.
module rph_md5_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rph_pkg::core_ctl_t     ctl,
	input  logic [511:0]           msg,
	output logic [127:0]           digest
);
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] h0_q, h1_q, h2_q, h3_q;
	logic [31:0] f, t, m, rot;
	logic [4:0]  s;

	always_comb begin
		unique case (ctl.idx[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (d_q & b_q) | (~d_q & c_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		m   = msg[32*rph_pkg::md5_g(ctl.idx) +: 32];
		s   = rph_pkg::md5_rot(ctl.idx);
		t   = a_q + f + rph_pkg::md5_k(ctl.idx) + m;
		rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h0_q <= '0; h1_q <= '0; h2_q <= '0; h3_q <= '0;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
		end else if (ctl.init) begin
			h0_q <= 32'h67452301; h1_q <= 32'hefcdab89;
			h2_q <= 32'h98badcfe; h3_q <= 32'h10325476;
			a_q <= 32'h67452301; b_q <= 32'hefcdab89;
			c_q <= 32'h98badcfe; d_q <= 32'h10325476;
		end else if (ctl.round) begin
			a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
		end else if (ctl.fold) begin
			h0_q <= h0_q + a_q; h1_q <= h1_q + b_q;
			h2_q <= h2_q + c_q; h3_q <= h3_q + d_q;
			a_q <= h0_q + a_q; b_q <= h1_q + b_q;
			c_q <= h2_q + c_q; d_q <= h3_q + d_q;
		end
	end

	assign digest = {h3_q, h2_q, h1_q, h0_q};
endmodule

// ===== design/radius_pap_password_hiding.sv =====
// RADIUS PAP password hiding: out = block ^ MD5(secret || seed), result becomes
// the next seed. A load word is taken while idle, only sets the seed and gives no
// result. An encode word hashes one MD5 block when secret_length+16 <= 55 and two
// otherwise: 64 rounds per MD5 block through one shared round unit, with init
// before the rounds, a fold after each block and a final xor before the result.
// The input is not ready while a word is being encoded or its result waits.
module radius_pap_password_hiding #(
	parameter int MAX_SECRET_BYTES = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,  // data_high[63:0], data_low[127:64], valid_bytes[132:128]
	input  logic         s_tlast,  // final_block
	input  logic         s_tuser,  // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // hidden_high[63:0], hidden_low[127:64]
	output logic         m_tlast,  // final_out
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_INIT = 3'd1, ST_ROUND = 3'd2,
		ST_FOLD = 3'd3, ST_XOR = 3'd4, ST_OUT = 3'd5;

	logic [2:0]   state_q;
	logic [5:0]   idx_q;
	logic         blk_q;
	logic [5:0]   len_q;
	logic [63:0]  sec_q [rph_pkg::SECRET_WORDS];
	logic [127:0] seed_q, data_q, res_q;
	logic [4:0]   vb_q;
	logic         last_q;
	logic [5:0]   len_sat;
	logic         two_blk;
	logic [7:0]   buf_b [128];
	logic [511:0] msg;
	logic [127:0] digest;
	rph_pkg::core_ctl_t ctl;
	logic [6:0]   n;
	logic [9:0]   bits;

	assign len_sat = (len_q > 6'(MAX_SECRET_BYTES)) ? 6'(MAX_SECRET_BYTES) : len_q;
	assign n       = 7'(len_sat) + 7'd16;
	assign bits    = {n, 3'b000};
	assign two_blk = (n > 7'd55);

	// message bytes of the padded secret || seed
	always_comb begin
		for (int i = 0; i < 128; i++) begin
			if (i < int'(len_sat))
				buf_b[i] = sec_q[(i >> 3) % rph_pkg::SECRET_WORDS][8*(7-(i%8)) +: 8];
			else if (i < int'(n))
				buf_b[i] = seed_q[64*((i-int'(len_sat))/8) + 8*(7-((i-int'(len_sat))%8)) +: 8];
			else if (i == int'(n))
				buf_b[i] = 8'h80;
			else
				buf_b[i] = 8'h00;
		end
		if (two_blk) begin
			buf_b[120] = bits[7:0];
			buf_b[121] = {6'd0, bits[9:8]};
		end else begin
			buf_b[56] = bits[7:0];
			buf_b[57] = {6'd0, bits[9:8]};
		end
		for (int j = 0; j < 64; j++)
			msg[8*j +: 8] = blk_q ? buf_b[64+j] : buf_b[j];
	end

	always_comb begin
		ctl.init  = (state_q == ST_INIT);
		ctl.round = (state_q == ST_ROUND);
		ctl.fold  = (state_q == ST_FOLD);
		ctl.idx   = idx_q;
	end

	rph_md5_core u_core (.clk(clk), .arst_n(arst_n), .ctl(ctl), .msg(msg), .digest(digest));

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = (state_q == ST_OUT);
	assign m_tdata   = res_q;
	assign m_tlast   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int w = 0; w < rph_pkg::SECRET_WORDS; w++) sec_q[w] <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == rph_pkg::REG_SECRET_LENGTH)
				len_q <= cfg_data[5:0];
			else if (cfg_index <= 3'(rph_pkg::SECRET_WORDS))
				sec_q[cfg_index - 3'd1] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_q <= s_tdata[127:0];
			vb_q   <= s_tdata[132:128];
			last_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			blk_q   <= 1'b0;
			seed_q  <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == rph_pkg::OP_LOAD)
							seed_q <= s_tdata[127:0];
						else
							state_q <= ST_INIT;
					end
					blk_q <= 1'b0;
					idx_q <= '0;
				end
				ST_INIT: state_q <= ST_ROUND;
				ST_ROUND: begin
					idx_q <= idx_q + 6'd1;
					if (idx_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					if (two_blk && !blk_q) begin
						blk_q <= 1'b1;
						state_q <= ST_ROUND;
					end else
						state_q <= ST_XOR;
				end
				ST_XOR: begin
					for (int i = 0; i < 16; i++) begin
						res_q[64*(i/8) + 8*(7-(i%8)) +: 8] <=
							((i < int'(vb_q)) ? data_q[64*(i/8) + 8*(7-(i%8)) +: 8] : 8'h00)
							^ digest[8*i +: 8];
						seed_q[64*(i/8) + 8*(7-(i%8)) +: 8] <=
							((i < int'(vb_q)) ? data_q[64*(i/8) + 8*(7-(i%8)) +: 8] : 8'h00)
							^ digest[8*i +: 8];
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/rph_checker.sv =====
// Port checker for the RADIUS password hiding block, bound to the top level.
// Depends on radius_pap_password_hiding_macros.svh.
`include "radius_pap_password_hiding_macros.svh"
module rph_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);
	`RPH_ASSERT_IMP(a_no_in_while_out, clk, arst_n, m_tvalid, !s_tready, "input ready with result pending")
	`RPH_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
	`RPH_ASSERT_NXT(a_enc_busy, clk, arst_n, s_tvalid && s_tready && s_tuser, !s_tready && !m_tvalid, "encode not busy")
endmodule

bind radius_pap_password_hiding rph_checker u_rph_checker (.*);

// ===== sim/tb_radius_pap_password_hiding.sv =====
// Self-checking bench for radius_pap_password_hiding: drives load and encode words,
// predicts hidden blocks with a local MD5 model and compares each output word.
// Depends on rph_pkg and the block itself.
`timescale 1ns / 1ps

module tb_radius_pap_password_hiding;
	typedef struct {
		logic        op;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [4:0]  vbytes;
		logic        fin;
	} pw_word_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        fin;
	} hidden_t;

	localparam int LIMIT_CYCLES = 2_500_000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;   // data_high, data_low, valid_bytes, zero fill
	logic         s_tlast;   // final_block
	logic         s_tuser;   // operation
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;   // hidden_high, hidden_low
	logic         m_tlast;   // final_out
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;

	radius_pap_password_hiding dut (.*);

	// model state
	logic [5:0]  key_len;
	logic [63:0] key_word [rph_pkg::SECRET_WORDS];
	logic [63:0] seed_hi, seed_lo;

	pw_word_t pending_words[$];
	hidden_t  hidden_expected[$];
	int errors = 0;
	int send_idle = 26, recv_idle = 63;
	bit feed_hold = 0;
	longint cycles = 0;

	int unsigned kt [64];
	int unsigned rt [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

	initial begin
		for (int i = 0; i < 64; i++)
			kt[i] = 32'(longint'($floor(((2.0 ** 32) *
				(($sin(i + 1.0) < 0) ? -$sin(i + 1.0) : $sin(i + 1.0))))));
	end

	function automatic void md5_compress(inout logic [31:0] h [4], input logic [7:0] blk [128],
			input int base);
		logic [31:0] m [16];
		logic [31:0] a, b, c, d, f, t;
		int g;
		for (int i = 0; i < 16; i++)
			m[i] = {blk[base+4*i+3], blk[base+4*i+2], blk[base+4*i+1], blk[base+4*i]};
		a = h[0]; b = h[1]; c = h[2]; d = h[3];
		for (int i = 0; i < 64; i++) begin
			if (i < 16) begin f = (b & c) | (~b & d); g = i; end
			else if (i < 32) begin f = (d & b) | (~d & c); g = (5 * i + 1) % 16; end
			else if (i < 48) begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
			else begin f = c ^ (b | ~d); g = (7 * i) % 16; end
			t = a + f + kt[i] + m[g];
			a = d; d = c; c = b;
			b = b + ((t << rt[(i / 16) * 4 + i % 4]) | (t >> (32 - rt[(i / 16) * 4 + i % 4])));
		end
		h[0] += a; h[1] += b; h[2] += c; h[3] += d;
	endfunction

	function automatic hidden_t hide_block(pw_word_t w);
		logic [7:0] buf8 [128];
		logic [31:0] h [4] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
		logic [7:0] dig [16];
		logic [127:0] seed, blk, res;
		logic [63:0] bits;
		int len, n, total, nv;
		hidden_t r;
		len = (key_len > 48) ? 48 : key_len;
		seed = {seed_hi, seed_lo};
		blk = {w.hi, w.lo};
		foreach (buf8[i]) buf8[i] = 8'h00;
		for (int i = 0; i < len; i++) buf8[i] = key_word[i / 8][63 - 8 * (i % 8) -: 8];
		for (int i = 0; i < 16; i++) buf8[len + i] = seed[127 - 8 * i -: 8];
		n = len + 16;
		buf8[n] = 8'h80;
		total = (n <= 55) ? 64 : 128;
		bits = 64'(n * 8);
		for (int i = 0; i < 8; i++) buf8[total - 8 + i] = bits[8 * i +: 8];
		md5_compress(h, buf8, 0);
		if (total == 128) md5_compress(h, buf8, 64);
		for (int i = 0; i < 16; i++) dig[i] = h[i / 4][8 * (i % 4) +: 8];
		nv = (w.vbytes > 16) ? 16 : w.vbytes;
		for (int i = 0; i < 16; i++)
			res[127 - 8 * i -: 8] = ((i < nv) ? blk[127 - 8 * i -: 8] : 8'h00) ^ dig[i];
		r.hi = res[127:64]; r.lo = res[63:0]; r.fin = w.fin;
		return r;
	endfunction

	function automatic void absorb_word(pw_word_t w);
		hidden_t r;
		if (w.op == rph_pkg::OP_LOAD) begin
			seed_hi = w.hi; seed_lo = w.lo;
		end else begin
			r = hide_block(w);
			seed_hi = r.hi; seed_lo = r.lo;
			hidden_expected.push_back(r);
		end
	endfunction

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			s_tuser <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
			if (!s_tvalid || s_tready) begin
				if (s_tvalid) absorb_word(pending_words.pop_front());
				if (pending_words.size() > 0 && !feed_hold
						&& $urandom_range(99) >= send_idle) begin
					s_tvalid <= 1'b1;
					s_tuser <= pending_words[0].op;
					s_tdata <= {3'b0, pending_words[0].vbytes, pending_words[0].lo,
						pending_words[0].hi};
					s_tlast <= pending_words[0].fin;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		hidden_t e;
		if (arst_n) begin
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("*** FAILED ***");
				$finish;
			end
			if (m_tvalid && m_tready) begin
				if (hidden_expected.size() == 0) begin
					errors++;
					$display("%0t: unexpected word %h last %b", $time, m_tdata, m_tlast);
				end else begin
					e = hidden_expected.pop_front();
					if (m_tdata[63:0] !== e.hi) begin
						errors++;
						$display("%0t: hidden_high exp %h got %h", $time, e.hi, m_tdata[63:0]);
					end
					if (m_tdata[127:64] !== e.lo) begin
						errors++;
						$display("%0t: hidden_low exp %h got %h", $time, e.lo, m_tdata[127:64]);
					end
					if (m_tlast !== e.fin) begin
						errors++;
						$display("%0t: final_out exp %b got %b", $time, e.fin, m_tlast);
					end
				end
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic void queue_word(logic op, logic [63:0] hi, logic [63:0] lo,
			logic [4:0] vb, logic fin);
		pw_word_t w;
		w.op = op; w.hi = hi; w.lo = lo; w.vbytes = vb; w.fin = fin;
		pending_words.push_back(w);
	endfunction

	task automatic wait_drained();
		while (pending_words.size() > 0 || s_tvalid || hidden_expected.size() > 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx == rph_pkg::REG_SECRET_LENGTH) key_len = val[5:0];
		else if (idx <= rph_pkg::SECRET_WORDS) key_word[idx - 1] = val;
	endtask

	task automatic set_secret(logic [5:0] len, bit ones);
		write_reg(rph_pkg::REG_SECRET_LENGTH, {58'b0, len});
		for (int i = 1; i <= rph_pkg::SECRET_WORDS; i++)
			write_reg(3'(i), ones ? '1 : rand64());
	endtask

	// random passwords: mostly start word then 1..4 blocks, some noise
	task automatic random_passwords(int n_words);
		int made = 0, nb;
		while (made < n_words) begin
			if ($urandom_range(9) == 0) begin
				queue_word(1'($urandom_range(1)), rand64(), rand64(),
					5'($urandom_range(31)), 1'($urandom_range(1)));
				made++;
			end else begin
				queue_word(rph_pkg::OP_LOAD, rand64(), rand64(), 5'($urandom),
					1'($urandom_range(1)));
				nb = $urandom_range(1, 4);
				for (int b = 0; b < nb; b++)
					queue_word(rph_pkg::OP_ENCODE, rand64(), rand64(),
						5'(($urandom_range(3) == 0) ? $urandom_range(31) : 16),
						b == nb - 1);
				made += nb + 1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		key_len = '0;
		foreach (key_word[i]) key_word[i] = '0;
		seed_hi = '0; seed_lo = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: encode with no seed load, zero secret
		queue_word(rph_pkg::OP_ENCODE, '1, '1, 5'd16, 1'b0);
		queue_word(rph_pkg::OP_ENCODE, '0, '0, 5'd0, 1'b1);
		wait_drained();
		set_secret(6'd48, 1'b1);
		queue_word(rph_pkg::OP_LOAD, '1, '0, 5'd0, 1'b0);
		queue_word(rph_pkg::OP_ENCODE, '1, '1, 5'd31, 1'b0);
		queue_word(rph_pkg::OP_ENCODE, 64'h0123456789abcdef, '1, 5'd7, 1'b0);
		queue_word(rph_pkg::OP_ENCODE, '1, '1, 5'd17, 1'b1);
		wait_drained();
		set_secret(6'd63, 1'b0);
		write_reg(3'd7, '1);
		queue_word(rph_pkg::OP_LOAD, rand64(), rand64(), 5'd16, 1'b1);
		queue_word(rph_pkg::OP_ENCODE, rand64(), rand64(), 5'd1, 1'b1);
		queue_word(rph_pkg::OP_LOAD, rand64(), rand64(), 5'd0, 1'b0);
		queue_word(rph_pkg::OP_ENCODE, rand64(), rand64(), 5'd15, 1'b0);
		queue_word(rph_pkg::OP_ENCODE, rand64(), rand64(), 5'd8, 1'b1);
		wait_drained();
		set_secret(6'd39, 1'b0);   // length + 16 = 55, one MD5 block
		queue_word(rph_pkg::OP_ENCODE, rand64(), rand64(), 5'd16, 1'b1);
		wait_drained();
		set_secret(6'd40, 1'b0);   // first length that needs two blocks
		queue_word(rph_pkg::OP_ENCODE, rand64(), rand64(), 5'd16, 1'b1);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 26 : (phase == 1) ? 63 : 0;
			recv_idle = (phase == 0) ? 63 : (phase == 1) ? 26 : 0;
			for (int s = 0; s < 3; s++) begin
				set_secret(6'($urandom_range(48)), 1'b0);
				random_passwords(130);
				wait_drained();
			end
			if (phase == 1) begin
				// let some words through, then hold the feed until all results are back
				random_passwords(20);
				repeat (400) @(posedge clk);
				feed_hold = 1'b1;
				repeat (5) @(posedge clk);
				while (hidden_expected.size() > 0 || s_tvalid) @(posedge clk);
				feed_hold = 1'b0;
				wait_drained();
			end
		end
		set_secret(6'd0, 1'b0);
		random_passwords(50);
		wait_drained();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
